@@ rtl/sobel_pkg.sv @@
// shared constants and controller/datapath interface types for the sobel edge block
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

  // line store depth and derived column index width
  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);

  // field and register widths
  localparam int PixW    = 8;
  localparam int CfgW    = 11;
  localparam int CfgIdxW = 1;
  localparam int GradW   = 10;
  localparam int SqW     = 2 * GradW;
  localparam int SumW    = SqW + 1;
  localparam int RootW   = 16;
  localparam int RootStepW = 3;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgImageWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgThreshold  = 1'b1;

  // register reset values
  localparam logic [CfgW-1:0] WidthReset  = CfgW'(MaxWidth);
  localparam logic [PixW-1:0] ThreshReset = 8'd100;

  // magnitude limits
  localparam logic [PixW-1:0] PixMax   = 8'd255;
  localparam logic [SumW-1:0] SatLimit = 21'd65280;

  // index of the last root iteration, one result bit each
  localparam logic [RootStepW-1:0] RootLastStep = 3'd7;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic look;
    logic grad;
    logic sq_x;
    logic sq_y;
    logic root_init;
    logic root_step;
    logic load;
    logic shift;
    logic second;
  } sobel_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic drop;
    logic emit_first;
    logic emit_second;
    logic out_free;
  } sobel_sts_t;

endpackage

`default_nettype wire

@@ rtl/sobel_edge_threshold.sv @@
// top level of the streaming 3x3 sobel edge detector with threshold
`timescale 1ns / 1ps
`default_nettype none

// Streaming Sobel edge detector. Pixels arrive in raster order; each output
// lags one row behind, the last pixel of a row wider than one pixel gives two
// requests, and a row of flush items (s_tuser_i = 1) delivers the final row
// with the bottom border replicated. An item that gives no result reads the
// line store, then updates it and the window; a flush before any complete row
// is dropped on intake. Each result then takes the gradient, two passes through
// the single shared squarer, root set-up, eight iterations of the bit-serial
// square root, and the output register load, which waits until the output
// register is free. The output register holds a finished result while the next pixel is taken in.

module sobel_edge_threshold
  import sobel_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  // input stream
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  input  wire logic [PixW-1:0]    s_tdata_i,   // [7:0] pixel
  input  wire logic               s_tuser_i,   // [0] op: flush when set
  // output stream
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [2*PixW-1:0]       m_tdata_o,   // [7:0] magnitude, [15:8] edge_pixel
  output logic                    m_tlast_o,   // row_end
  output logic                    m_tuser_o    // [0] frame_end
);

  sobel_cmd_t cmd;
  sobel_sts_t sts;

  // sequencer
  sobel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // data path
  sobel_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_op_i      (s_tuser_i),
    .s_pixel_i   (s_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o)
  );

endmodule

`default_nettype wire

@@ rtl/sobel_ctrl.sv @@
// controller state machine sequencing line read, gradient, root and output load
`timescale 1ns / 1ps
`default_nettype none

module sobel_ctrl
  import sobel_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire sobel_sts_t sts_i,
  output sobel_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLook  = 3'd1;
  localparam logic [2:0] StGrad  = 3'd2;
  localparam logic [2:0] StSqX   = 3'd3;
  localparam logic [2:0] StSqY   = 3'd4;
  localparam logic [2:0] StRinit = 3'd5;
  localparam logic [2:0] StRoot  = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [RootStepW-1:0] step_q, step_d;
  logic                 second_q, second_d;
  logic                 more_q, more_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    second_d   = second_q;
    more_d     = more_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    cmd_o.second = second_q;
    case (state_q)
      StIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.take = 1'b1;
          if (!sts_i.drop) begin
            state_d = StLook;
          end
        end
      end
      StLook: begin
        cmd_o.look = 1'b1;
        if (sts_i.emit_first) begin
          state_d  = StGrad;
          second_d = 1'b0;
          more_d   = sts_i.emit_second;
        end else if (sts_i.emit_second) begin
          state_d  = StGrad;
          second_d = 1'b1;
          more_d   = 1'b0;
        end else begin
          state_d = StIdle;
        end
      end
      StGrad: begin
        cmd_o.grad = 1'b1;
        state_d    = StSqX;
      end
      StSqX: begin
        cmd_o.sq_x = 1'b1;
        state_d    = StSqY;
      end
      StSqY: begin
        cmd_o.sq_y = 1'b1;
        state_d    = StRinit;
      end
      StRinit: begin
        cmd_o.root_init = 1'b1;
        step_d          = '0;
        state_d         = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == RootLastStep) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (more_q) begin
            // window moves on by the held column before the row-end request
            cmd_o.shift = 1'b1;
            more_d      = 1'b0;
            second_d    = 1'b1;
            state_d     = StGrad;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      step_q   <= '0;
      second_q <= 1'b0;
      more_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      second_q <= second_d;
      more_q   <= more_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sobel_dp.sv @@
// datapath: config registers, line store, window, gradient, square root and output register
`timescale 1ns / 1ps
`default_nettype none

module sobel_dp
  import sobel_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sobel_cmd_t         cmd_i,
  output sobel_sts_t              sts_o,
  input  wire logic               s_op_i,
  input  wire logic [PixW-1:0]    s_pixel_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [2*PixW-1:0]       m_tdata_o,
  output logic                    m_tlast_o,
  output logic                    m_tuser_o
);

  logic [CfgW-1:0]   width_q;
  logic [PixW-1:0]   thresh_q;
  logic [ColW-1:0]   col_q;
  logic              started_q;
  logic              flush_q;
  logic [PixW-1:0]   px_q;
  logic [2*PixW-1:0] line_mem [MaxWidth];
  logic [2*PixW-1:0] rd_q;
  logic [PixW-1:0]   win_q [3][3];
  logic [PixW-1:0]   hold_q [3];
  logic [GradW-1:0]  ax_q, ay_q;
  logic [SumW-1:0]   sum_q;
  logic [RootW-1:0]  v_q, r_q, bit_q;
  logic              sat_q;
  logic              out_valid_q;
  logic [2*PixW-1:0] out_data_q;
  logic              out_last_q, out_user_q;

  logic [CfgW-1:0]   wm1;
  logic              last;
  logic [PixW-1:0]   top, mid, bot;
  logic [GradW-1:0]  cw_new, cw_old, rw_bot, rw_top;
  logic [GradW-1:0]  mul_a;
  logic [SqW-1:0]    prod;
  logic [RootW:0]    trial;
  logic              rnd;
  logic [PixW:0]     mag_sum;
  logic [PixW-1:0]   mag, edge_px;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth: width_q  <= cfg_wdata_i;
        CfgThreshold:  thresh_q <= cfg_wdata_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  // effective last column: zero width acts as one, oversize as the store depth
  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (width_q > CfgW'(MaxWidth)) begin
      wm1 = CfgW'(MaxWidth - 1);
    end else begin
      wm1 = width_q - 1'b1;
    end
  end
  assign last = CfgW'(col_q) >= wm1;

  // column samples: first row replicates the pixel, a flush replicates the middle line
  always_comb begin
    if (!started_q) begin
      top = px_q;
      mid = px_q;
      bot = px_q;
    end else begin
      top = rd_q[2*PixW-1:PixW];
      mid = rd_q[PixW-1:0];
      bot = flush_q ? rd_q[PixW-1:0] : px_q;
    end
  end

  // status towards the controller
  assign sts_o.drop        = s_op_i && !started_q;
  assign sts_o.emit_first  = started_q && (col_q != '0);
  assign sts_o.emit_second = started_q && last;
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      flush_q <= s_op_i;
      px_q    <= s_pixel_i;
    end
  end

  // line store, upper line in the high byte, middle line in the low byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_q <= line_mem[col_q];
    end
    if (cmd_i.look) begin
      line_mem[col_q] <= {mid, bot};
    end
  end

  // column and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.look) begin
      if (last) begin
        col_q     <= '0;
        started_q <= !flush_q;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // 3x3 window, index [column][row], column 2 newest
  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      hold_q[0] <= top;
      hold_q[1] <= mid;
      hold_q[2] <= bot;
      if (col_q == '0) begin
        for (int c = 0; c < 3; c++) begin
          win_q[c][0] <= top;
          win_q[c][1] <= mid;
          win_q[c][2] <= bot;
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          win_q[0][k] <= win_q[1][k];
          win_q[1][k] <= win_q[2][k];
        end
        win_q[2][0] <= top;
        win_q[2][1] <= mid;
        win_q[2][2] <= bot;
      end
    end else if (cmd_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_q[0][k] <= win_q[1][k];
        win_q[1][k] <= win_q[2][k];
        win_q[2][k] <= hold_q[k];
      end
    end
  end

  // weighted column and row sums of the window
  assign cw_new = GradW'(win_q[2][0]) + {1'b0, win_q[2][1], 1'b0} + GradW'(win_q[2][2]);
  assign cw_old = GradW'(win_q[0][0]) + {1'b0, win_q[0][1], 1'b0} + GradW'(win_q[0][2]);
  assign rw_bot = GradW'(win_q[0][2]) + {1'b0, win_q[1][2], 1'b0} + GradW'(win_q[2][2]);
  assign rw_top = GradW'(win_q[0][0]) + {1'b0, win_q[1][0], 1'b0} + GradW'(win_q[2][0]);

  // absolute gradients
  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      ax_q <= (cw_new >= cw_old) ? cw_new - cw_old : cw_old - cw_new;
      ay_q <= (rw_bot >= rw_top) ? rw_bot - rw_top : rw_top - rw_bot;
    end
  end

  // one shared squarer, x then y
  assign mul_a = cmd_i.sq_x ? ax_q : ay_q;
  assign prod  = mul_a * mul_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_x) begin
      sum_q <= SumW'(prod);
    end else if (cmd_i.sq_y) begin
      sum_q <= sum_q + SumW'(prod);
    end
  end

  // digit-by-digit square root, one result bit per step
  assign trial = {1'b0, r_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      v_q   <= sum_q[RootW-1:0];
      r_q   <= '0;
      bit_q <= RootW'(1) << (RootW - 2);
      sat_q <= sum_q > SatLimit;
    end else if (cmd_i.root_step) begin
      if ({1'b0, v_q} >= trial) begin
        v_q <= v_q - trial[RootW-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // round up when the remainder exceeds the root, then saturate
  assign rnd     = v_q > r_q;
  assign mag_sum = {1'b0, r_q[PixW-1:0]} + (PixW+1)'(rnd);
  assign mag     = (sat_q || mag_sum[PixW] || (r_q[RootW-1:PixW] != '0)) ? PixMax
                                                                          : mag_sum[PixW-1:0];
  assign edge_px = (mag >= thresh_q) ? PixMax : '0;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {edge_px, mag};
      out_last_q <= cmd_i.second;
      out_user_q <= cmd_i.second && flush_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_user_q;

endmodule

`default_nettype wire
